// File: sv/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and codes for the sorted record table: the stored record,
// the result bundle, request kinds and status codes.
// ----------------------------------------------------------------------------
package srt_pkg;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_SEARCH = 2'd2;
   localparam logic [1:0] KIND_GROUP  = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic [39:0] TOTAL_MAX = 40'hFF_FFFF_FFFF;
   localparam logic [8:0]  GCNT_MAX  = 9'h1FF;

   typedef struct packed {
      logic [63:0] name;
      logic [63:0] publisher;
      logic [11:0] year;
      logic [31:0] sales;
   } record_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] found_year;
      logic [63:0] found_publisher;
      logic [31:0] found_sales;
      logic [39:0] group_total;
      logic [8:0]  group_count;
   } result_type;

endpackage

// File: sv/srt_if.sv
// ----------------------------------------------------------------------------
// srt request and response channels
// Valid/ready channels carrying one request or one result each.
// ----------------------------------------------------------------------------
interface srt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [63:0] name_key;
   logic [63:0] publisher_key;
   logic [11:0] release_year;
   logic [31:0] sales_value;

   modport source (output valid, kind, name_key, publisher_key, release_year,
                   sales_value, input ready);
   modport sink (input valid, kind, name_key, publisher_key, release_year,
                 sales_value, output ready);
endinterface

interface srt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [11:0] found_year;
   logic [63:0] found_publisher;
   logic [31:0] found_sales;
   logic [39:0] group_total;
   logic [8:0]  group_count;

   modport source (output valid, status, found_year, found_publisher, found_sales,
                   group_total, group_count, input ready);
   modport sink (input valid, status, found_year, found_publisher, found_sales,
                 group_total, group_count, output ready);
endinterface

// File: sv/srt_mem.sv
// ----------------------------------------------------------------------------
// srt_mem
// Record store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module srt_mem
   import srt_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  record_type    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output record_type    rd_data
);

   record_type entry_mem [DEPTH];
   record_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/srt_engine.sv
// ----------------------------------------------------------------------------
// srt_engine
// Request sequencer: walks the record store one entry per cycle, shifting
// entries for insert and remove, matching for search and group query.
// ----------------------------------------------------------------------------
module srt_engine
   import srt_pkg::*;
#(
   parameter int CAPACITY = 256,
   parameter int AW       = 8,
   parameter int CW       = 9
) (
   input  logic          clock,
   input  logic          reset,
   srt_req_if.sink       req,
   output logic          mem_rd_en,
   output logic [AW-1:0] mem_rd_addr,
   input  record_type    mem_rd_data,
   output logic          mem_wr_en,
   output logic [AW-1:0] mem_wr_addr,
   output record_type    mem_wr_data,
   output logic          res_valid,
   output result_type    res,
   input  logic          res_ready
);

   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   typedef enum logic [1:0] {IDLE, SCAN, PLACE, DONE} state_type;

   state_type     state_ff,  state_in;
   logic [1:0]    kind_ff,   kind_in;
   record_type    new_ff,    new_in;
   logic [CW-1:0] count_ff,  count_in;
   logic [AW-1:0] last_ff,   last_in;
   logic [AW-1:0] addr_ff,   addr_in;
   logic          issue_ff,  issue_in;
   logic          rdv_ff,    rdv_in;
   logic [AW-1:0] idx_ff,    idx_in;
   logic          found_ff,  found_in;
   logic [AW-1:0] place_ff,  place_in;
   result_type    res_ff,    res_in;

   always_comb begin
      logic        stop;
      logic        hit;
      logic [40:0] sum;
      logic [8:0]  gcnt;

      state_in = state_ff;
      kind_in  = kind_ff;
      new_in   = new_ff;
      count_in = count_ff;
      last_in  = last_ff;
      addr_in  = addr_ff;
      issue_in = issue_ff;
      rdv_in   = 1'b0;
      idx_in   = idx_ff;
      found_in = found_ff;
      place_in = place_ff;
      res_in   = res_ff;

      mem_rd_en   = 1'b0;
      mem_rd_addr = addr_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff;
      mem_wr_data = mem_rd_data;

      stop = 1'b0;
      hit  = 1'b0;
      sum  = '0;
      gcnt = res_ff.group_count;

      case (state_ff)
         IDLE: begin
            if (req.valid) begin
               kind_in       = req.kind;
               new_in.name      = req.name_key;
               new_in.publisher = req.publisher_key;
               new_in.year      = req.release_year;
               new_in.sales     = req.sales_value;
               res_in   = '0;
               found_in = 1'b0;
               last_in  = AW'(count_ff - 1'b1);
               if (req.kind == KIND_INSERT) begin
                  if (count_ff == CAP_CNT) begin
                     res_in.status = ST_FULL;
                     state_in      = DONE;
                  end else if (count_ff == '0) begin
                     place_in = '0;
                     state_in = PLACE;
                  end else begin
                     // insert walks from the tail towards the head
                     addr_in  = AW'(count_ff - 1'b1);
                     issue_in = 1'b1;
                     state_in = SCAN;
                  end
               end else if (count_ff == '0) begin
                  res_in.status = ST_MISS;
                  state_in      = DONE;
               end else begin
                  addr_in  = '0;
                  issue_in = 1'b1;
                  state_in = SCAN;
               end
            end
         end

         SCAN: begin
            if (rdv_ff) begin
               case (kind_ff)
                  KIND_INSERT: begin
                     if (new_ff.sales > mem_rd_data.sales) begin
                        // smaller entry moves one place towards the tail
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = AW'(idx_ff + 1'b1);
                        if (idx_ff == '0) begin
                           place_in = '0;
                           stop     = 1'b1;
                        end
                     end else begin
                        place_in = AW'(idx_ff + 1'b1);
                        stop     = 1'b1;
                     end
                     if (stop) begin
                        state_in = PLACE;
                     end
                  end
                  KIND_REMOVE: begin
                     hit = (mem_rd_data.name == new_ff.name);
                     if (found_ff) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = AW'(idx_ff - 1'b1);
                     end else if (hit) begin
                        found_in = 1'b1;
                     end
                     if (idx_ff == last_ff) begin
                        stop = 1'b1;
                        if (found_ff || hit) begin
                           count_in      = count_ff - 1'b1;
                           res_in.status = ST_OK;
                        end else begin
                           res_in.status = ST_MISS;
                        end
                        state_in = DONE;
                     end
                  end
                  KIND_SEARCH: begin
                     if (mem_rd_data.name == new_ff.name) begin
                        res_in.status          = ST_OK;
                        res_in.found_year      = mem_rd_data.year;
                        res_in.found_publisher = mem_rd_data.publisher;
                        res_in.found_sales     = mem_rd_data.sales;
                        stop     = 1'b1;
                        state_in = DONE;
                     end else if (idx_ff == last_ff) begin
                        res_in.status = ST_MISS;
                        stop     = 1'b1;
                        state_in = DONE;
                     end
                  end
                  default: begin
                     if (mem_rd_data.publisher == new_ff.publisher) begin
                        sum = {1'b0, res_ff.group_total} + {9'd0, mem_rd_data.sales};
                        res_in.group_total = sum[40] ? TOTAL_MAX : sum[39:0];
                        if (res_ff.group_count != GCNT_MAX) begin
                           gcnt = res_ff.group_count + 1'b1;
                        end
                        res_in.group_count = gcnt;
                     end
                     if (idx_ff == last_ff) begin
                        res_in.status = (gcnt == '0) ? ST_MISS : ST_OK;
                        stop     = 1'b1;
                        state_in = DONE;
                     end
                  end
               endcase
            end

            if (stop) begin
               issue_in = 1'b0;
            end else if (issue_ff) begin
               mem_rd_en = 1'b1;
               rdv_in    = 1'b1;
               idx_in    = addr_ff;
               if (kind_ff == KIND_INSERT) begin
                  if (addr_ff == '0) begin
                     issue_in = 1'b0;
                  end else begin
                     addr_in = addr_ff - 1'b1;
                  end
               end else begin
                  if (addr_ff == last_ff) begin
                     issue_in = 1'b0;
                  end else begin
                     addr_in = addr_ff + 1'b1;
                  end
               end
            end
         end

         PLACE: begin
            mem_wr_en     = 1'b1;
            mem_wr_addr   = place_ff;
            mem_wr_data   = new_ff;
            count_in      = count_ff + 1'b1;
            res_in.status = ST_OK;
            state_in      = DONE;
         end

         DONE: begin
            if (res_ready) begin
               state_in = IDLE;
            end
         end

         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         count_ff <= '0;
         issue_ff <= 1'b0;
         rdv_ff   <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         issue_ff <= issue_in;
         rdv_ff   <= rdv_in;
         found_ff <= found_in;
      end
      kind_ff  <= kind_in;
      new_ff   <= new_in;
      last_ff  <= last_in;
      addr_ff  <= addr_in;
      idx_ff   <= idx_in;
      place_ff <= place_in;
      res_ff   <= res_in;
   end

   assign req.ready = (state_ff == IDLE);
   assign res_valid = (state_ff == DONE);
   assign res       = res_ff;

endmodule

// File: sv/srt_out.sv
// ----------------------------------------------------------------------------
// srt_out
// Result holding register between the sequencer and the response channel.
// ----------------------------------------------------------------------------
module srt_out
   import srt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       res_valid,
   input  result_type res,
   output logic       res_ready,
   srt_rsp_if.source  rsp
);

   logic       vld_ff;
   logic       vld_in;
   result_type data_ff;
   result_type data_in;

   always_comb begin
      res_ready = !vld_ff || rsp.ready;
      vld_in    = vld_ff;
      data_in   = data_ff;
      if (res_ready) begin
         vld_in  = res_valid;
         data_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      data_ff <= data_in;
   end

   assign rsp.valid           = vld_ff;
   assign rsp.status          = data_ff.status;
   assign rsp.found_year      = data_ff.found_year;
   assign rsp.found_publisher = data_ff.found_publisher;
   assign rsp.found_sales     = data_ff.found_sales;
   assign rsp.group_total     = data_ff.group_total;
   assign rsp.group_count     = data_ff.group_count;

endmodule

// File: sv/sorted_record_table.sv
// ----------------------------------------------------------------------------
// sorted_record_table
// Records held in descending order of sales, with insert, remove by name,
// search by name and per-publisher sales totals.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one request (kind, name key, publisher key, year, sales);
//   it is taken only while the sequencer is idle. rsp_ch returns exactly one
//   result per request, in request order.
//   Each request walks the record memory one entry per cycle through its
//   single read port, so the time between requests grows with the number
//   of stored entries n: a search that hits early or an insert that lands
//   near the tail ends the walk sooner, and an empty table or an insert
//   that finds it full skips the walk. The next request is taken the cycle
//   after the result enters the output register.
//   Insert and remove shift entries in the same walk: the write goes one
//   place behind or ahead of the read, so the two never meet.
//   Reset empties the table at once (entry count cleared, no sweep).
//   If rsp_ch stalls, one result waits in the output register, one more
//   waits in the sequencer, and no further request is taken.
// ----------------------------------------------------------------------------
module sorted_record_table
   import srt_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic      clock,
   input  logic      reset,
   srt_req_if.sink   req_ch,
   srt_rsp_if.source rsp_ch
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   record_type    mem_rd_data;
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   record_type    mem_wr_data;
   logic          res_valid;
   logic          res_ready;
   result_type    res;

   srt_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   srt_engine #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .res_valid   (res_valid),
      .res         (res),
      .res_ready   (res_ready)
   );

   srt_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready),
      .rsp       (rsp_ch)
   );

endmodule
